FILE: hw/rtl/gnd_pkg.sv
// Shared types and constants for the greedy note dispenser.
// Holds field widths, register indexes, reset values and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package gnd_pkg;

  // Field widths
  localparam int AMT_W     = 31;
  localparam int DEN_W     = 20;
  localparam int DCNT_W    = 3;
  localparam int DEN_REGS  = 6;
  localparam int CFG_IDX_W = 3;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 88;

  // Divider: one quotient bit per cycle
  localparam int DIV_STEPS = AMT_W;
  localparam int STEP_W    = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEN_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_LAST  = 3'd6;

  // Reset values
  localparam logic [DCNT_W-1:0] DEN_COUNT_RESET = 3'd6;
  localparam logic [DEN_REGS-1:0][DEN_W-1:0] DEN_RESET = {
    20'd10000, 20'd20000, 20'd50000, 20'd100000, 20'd200000, 20'd500000
  };

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_EMIT
  } gnd_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // take a new request and sort the denominations
    logic div_start;  // begin dividing the remaining amount
    logic emit;       // load one result into the output register
  } gnd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;   // divider idle, results valid
    logic last_item;  // current denomination is the final one
    logic out_free;   // output register can take a result this cycle
  } gnd_sts_t;

endpackage

FILE: hw/rtl/gnd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Divides the 31-bit amount by a 20-bit denomination. Depends on gnd_pkg.
`timescale 1ns / 1ps

module gnd_div
  import gnd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AMT_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [AMT_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [AMT_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_r, quo_r[AMT_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  // Next-state logic for the shift registers and step counter.
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[AMT_W-2:0], ge};
      rem_nxt  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: hw/rtl/gnd_datapath.sv
// Datapath of the note dispenser: configuration registers, stable
// descending sort, remaining amount, divider and output register.
// Depends on gnd_pkg and gnd_div.
`timescale 1ns / 1ps

module gnd_datapath
  import gnd_pkg::*;
#(
  parameter int MAX_DENOMINATIONS = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DEN_W-1:0]       cfg_data,
  // request amount
  input  logic [AMT_W-1:0]       amount,
  // controller link
  input  gnd_cmd_t               cmd,
  output gnd_sts_t               sts,
  // result register
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int ACT_MAX = (MAX_DENOMINATIONS < DEN_REGS) ? MAX_DENOMINATIONS : DEN_REGS;
  localparam int CNT_W   = $clog2(ACT_MAX + 1);
  localparam int SEL_W   = (ACT_MAX > 1) ? $clog2(ACT_MAX) : 1;

  // Configuration registers
  logic [DCNT_W-1:0]                den_count_r;
  logic [DEN_REGS-1:0][DEN_W-1:0]   den_r;

  // Request state
  logic [ACT_MAX-1:0][DEN_W-1:0]    sorted_r, sorted_nxt;
  logic [CNT_W-1:0]                 n_r, n_nxt;
  logic [CNT_W-1:0]                 idx_r, idx_nxt;
  logic [AMT_W-1:0]                 left_r, left_nxt;

  // Output register
  logic                             out_valid_r, out_valid_nxt;
  logic [DEN_W-1:0]                 out_value_r;
  logic [AMT_W-1:0]                 out_count_r;
  logic [AMT_W-1:0]                 out_left_r;
  logic                             out_last_r;

  // Divider link
  logic             div_busy;
  logic [AMT_W-1:0] div_quo;
  logic [DEN_W-1:0] div_rem;

  logic [DEN_W-1:0] cur_den;
  logic             bypass;
  logic [AMT_W-1:0] cnt_res;
  logic [AMT_W-1:0] left_res;

  logic [DEN_REGS-1:0][CNT_W-1:0] rank;

  // Register writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      den_count_r <= DEN_COUNT_RESET;
      den_r       <= DEN_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DEN_COUNT) begin
        den_count_r <= cfg_data[DCNT_W-1:0];
      end else if (cfg_index >= REG_DEN_FIRST && cfg_index <= REG_DEN_LAST) begin
        den_r[cfg_index - REG_DEN_FIRST] <= cfg_data;
      end
    end
  end

  // Number of denominations in use, clamped to one and to ACT_MAX.
  always_comb begin
    if (den_count_r == '0) begin
      n_nxt = CNT_W'(1);
    end else if (int'(den_count_r) > ACT_MAX) begin
      n_nxt = CNT_W'(ACT_MAX);
    end else begin
      n_nxt = CNT_W'(den_count_r);
    end
  end

  // Rank of each active denomination: larger values first, ties by index.
  always_comb begin
    for (int k = 0; k < DEN_REGS; k++) begin
      rank[k] = '0;
      for (int j = 0; j < DEN_REGS; j++) begin
        if (j != k && j < int'(n_nxt)) begin
          if (den_r[j] > den_r[k] || (den_r[j] == den_r[k] && j < k)) begin
            rank[k] = rank[k] + CNT_W'(1);
          end
        end
      end
    end
  end

  // Place each active denomination at its rank.
  always_comb begin
    for (int r = 0; r < ACT_MAX; r++) begin
      sorted_nxt[r] = '0;
      for (int k = 0; k < DEN_REGS; k++) begin
        if (k < int'(n_nxt) && rank[k] == CNT_W'(r)) begin
          sorted_nxt[r] = den_r[k];
        end
      end
    end
  end

  // Divider over the remaining amount and the current denomination.
  assign cur_den = sorted_r[idx_r[SEL_W-1:0]];

  gnd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (left_r),
    .divisor   (cur_den),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Nothing to take when the amount is spent or the note value is zero.
  assign bypass   = (left_r == '0) || (cur_den == '0);
  assign cnt_res  = bypass ? '0 : div_quo;
  assign left_res = bypass ? left_r : {{(AMT_W-DEN_W){1'b0}}, div_rem};

  // Request state next values.
  always_comb begin
    idx_nxt  = idx_r;
    left_nxt = left_r;
    if (cmd.load) begin
      idx_nxt  = '0;
      left_nxt = amount;
    end else if (cmd.emit) begin
      idx_nxt  = idx_r + CNT_W'(1);
      left_nxt = left_res;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    left_r <= left_nxt;
    if (cmd.load) begin
      n_r      <= n_nxt;
      sorted_r <= sorted_nxt;
    end
  end

  // Output register: a new result may enter as the held one leaves.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= cur_den;
      out_count_r <= cnt_res;
      out_left_r  <= left_res;
      out_last_r  <= sts.last_item;
    end
  end

  // Status back to the controller.
  assign sts.div_done  = !div_busy;
  assign sts.last_item = (idx_r == n_r - CNT_W'(1));
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - DEN_W - 2*AMT_W){1'b0}},
                       out_left_r, out_count_r, out_value_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: hw/rtl/gnd_ctrl.sv
// Controller state machine of the note dispenser: sequences request
// intake, one division per denomination and result hand-off. Depends on gnd_pkg.
`timescale 1ns / 1ps

module gnd_ctrl
  import gnd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  gnd_sts_t sts,
  output gnd_cmd_t cmd
);

  gnd_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last_item ? ST_IDLE : ST_START;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/greedy_note_dispenser.sv
// Greedy note dispenser: splits a request over up to six note values.
// Each result passes through a start step, the shared one-bit-per-cycle divider,
// a check that the divider has finished and a hand-off to the output register,
// which waits while the receiver leaves the output register full. A new request
// is taken only once the last result of the previous one has been handed off.
// Synchronous active-low reset restores the default note values and count.
`timescale 1ns / 1ps

module greedy_note_dispenser
  import gnd_pkg::*;
#(
  parameter int MAX_DENOMINATIONS = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [30:0] amount
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [19:0] note_value, [50:20] note_count,
                                             // [81:51] amount_left
  output logic                   out_tlast,  // last
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DEN_W-1:0]       cfg_data
);

  gnd_cmd_t cmd;
  gnd_sts_t sts;

  // Sequencer.
  gnd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Registers, sort, divider and output stage.
  gnd_datapath #(
    .MAX_DENOMINATIONS (MAX_DENOMINATIONS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .amount     (in_tdata[AMT_W-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
